/* rtl/arp_rr_pkg.sv */
// arp_rr_pkg: types and constants shared by the arp request responder
// holds the channel payload structs, the front-to-back record and header constants
// no dependencies
`timescale 1ns / 1ps

package arp_rr_pkg;

    // header capture
    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] HEADER_LEN = 5'd28;

    // arp header constants
    localparam logic [15:0] HTYPE_ETH  = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  HLEN_MAC   = 8'd6;
    localparam logic [7:0]  PLEN_IPV4  = 8'd4;
    localparam logic [15:0] OPER_REQ   = 16'h0001;
    localparam logic [15:0] OPER_REPLY = 16'h0002;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OWN_IP  = 1'b0,
        REG_OWN_MAC = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } rx_item_t;

    typedef struct packed {
        logic        packet_ok;
        logic        learn_valid;
        logic [47:0] learn_mac;
        logic [31:0] learn_ip;
        logic        reply_valid;
        logic [47:0] reply_dst_mac;
        logic [47:0] reply_sender_mac;
        logic [31:0] reply_sender_ip;
        logic [31:0] reply_target_ip;
    } res_item_t;

    // fields picked out of the header as bytes arrive
    typedef struct packed {
        logic [15:0] htype;
        logic [15:0] ptype;
        logic [7:0]  hlen;
        logic [7:0]  plen;
        logic [15:0] oper;
        logic [47:0] sha;
        logic [31:0] spa;
        logic [31:0] tpa;
    } hdr_t;

    // one classified frame, handed from front to back
    typedef struct packed {
        logic        ok;
        logic        learn;
        logic        is_request;
        logic [47:0] sha;
        logic [31:0] spa;
        logic [31:0] tpa;
    } rec_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_stat_t;

endpackage

/* rtl/arp_rr_front.sv */
// arp_rr_front: byte capture and header classification
// depends on arp_rr_pkg
`timescale 1ns / 1ps

module arp_rr_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  arp_rr_pkg::rx_item_t item,
    output logic                 push,
    output arp_rr_pkg::rec_t     rec
);

    logic [arp_rr_pkg::CNT_W-1:0] cnt_reg;
    logic [arp_rr_pkg::CNT_W-1:0] cnt_next;
    logic [arp_rr_pkg::CNT_W-1:0] cnt_inc;
    arp_rr_pkg::hdr_t             hdr_reg;
    arp_rr_pkg::hdr_t             hdr_next;
    logic                         take;
    logic                         long_enough;
    logic [2:0]                   sha_idx;
    logic [1:0]                   spa_idx;
    logic [1:0]                   tpa_idx;
    logic                         ok;
    logic                         mac_uni;
    logic                         ip_uni;

    assign take    = cnt_reg < arp_rr_pkg::HEADER_LEN;
    assign cnt_inc = take ? cnt_reg + 1'b1 : cnt_reg;
    assign sha_idx = 3'(5'd13 - cnt_reg);
    assign spa_idx = 2'(5'd17 - cnt_reg);
    assign tpa_idx = 2'(5'd27 - cnt_reg);

    // header with the current byte merged in
    always_comb
    begin
        hdr_next = hdr_reg;
        if (take)
        begin
            case (cnt_reg) inside
                5'd0:           hdr_next.htype[15:8] = item.rx_byte;
                5'd1:           hdr_next.htype[7:0]  = item.rx_byte;
                5'd2:           hdr_next.ptype[15:8] = item.rx_byte;
                5'd3:           hdr_next.ptype[7:0]  = item.rx_byte;
                5'd4:           hdr_next.hlen        = item.rx_byte;
                5'd5:           hdr_next.plen        = item.rx_byte;
                5'd6:           hdr_next.oper[15:8]  = item.rx_byte;
                5'd7:           hdr_next.oper[7:0]   = item.rx_byte;
                [5'd8:5'd13]:   hdr_next.sha[8*sha_idx +: 8] = item.rx_byte;
                [5'd14:5'd17]:  hdr_next.spa[8*spa_idx +: 8] = item.rx_byte;
                [5'd24:5'd27]:  hdr_next.tpa[8*tpa_idx +: 8] = item.rx_byte;
                default:        hdr_next = hdr_reg;  // target mac is not kept
            endcase
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            cnt_next = item.frame_end ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hdr_reg <= hdr_next;
        end
    end

    // classification on the last byte
    assign long_enough = cnt_inc == arp_rr_pkg::HEADER_LEN;
    assign ok = long_enough
              && hdr_next.htype == arp_rr_pkg::HTYPE_ETH
              && hdr_next.ptype == arp_rr_pkg::PTYPE_IPV4
              && hdr_next.hlen == arp_rr_pkg::HLEN_MAC
              && hdr_next.plen == arp_rr_pkg::PLEN_IPV4
              && hdr_next.sha != '0
              && hdr_next.sha != '1;
    // group bit is the lowest bit of the first octet
    assign mac_uni = !hdr_next.sha[40];
    assign ip_uni  = hdr_next.spa != '0 && hdr_next.spa != '1
                   && hdr_next.spa[31:28] != 4'hE;

    assign push           = accept && item.frame_end;
    assign rec.ok         = ok;
    assign rec.learn      = ok && mac_uni && ip_uni;
    assign rec.is_request = hdr_next.oper == arp_rr_pkg::OPER_REQ;
    assign rec.sha        = hdr_next.sha;
    assign rec.spa        = hdr_next.spa;
    assign rec.tpa        = hdr_next.tpa;

endmodule

/* rtl/arp_rr_queue.sv */
// arp_rr_queue: two-entry queue of classified frames between front and back
// depends on arp_rr_pkg
`timescale 1ns / 1ps

module arp_rr_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  arp_rr_pkg::rec_t    wr_rec,
    input  logic                pop,
    output arp_rr_pkg::rec_t    rd_rec,
    output arp_rr_pkg::q_stat_t stat
);

    arp_rr_pkg::rec_t entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic             do_push;
    logic             do_pop;

    assign do_push = push && cnt_reg != 2'd2;
    assign do_pop  = pop && cnt_reg != 2'd0;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = 2'(cnt_reg + {1'b0, do_push} - {1'b0, do_pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    assign rd_rec         = entry_reg[rd_ptr_reg];
    assign stat.not_empty = cnt_reg != 2'd0;
    assign stat.full      = cnt_reg == 2'd2;

endmodule

/* rtl/arp_rr_back.sv */
// arp_rr_back: reply decision and result register
// depends on arp_rr_pkg
`timescale 1ns / 1ps

module arp_rr_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  arp_rr_pkg::rec_t      rec,
    input  logic                  rec_valid,
    output logic                  pop,
    input  logic [31:0]           own_ip,
    input  logic [47:0]           own_mac,
    output logic                  res_valid,
    input  logic                  res_ready,
    output arp_rr_pkg::res_item_t res_item
);

    logic                  out_valid_reg;
    logic                  out_valid_next;
    arp_rr_pkg::res_item_t out_data_reg;
    arp_rr_pkg::res_item_t out_data_next;
    logic                  reply;

    assign pop   = rec_valid && (!out_valid_reg || res_ready);
    assign reply = rec.ok && rec.is_request && rec.tpa == own_ip;

    always_comb
    begin
        out_data_next                  = '0;
        out_data_next.packet_ok        = rec.ok;
        out_data_next.learn_valid      = rec.learn;
        out_data_next.learn_mac        = rec.ok ? rec.sha : '0;
        out_data_next.learn_ip         = rec.ok ? rec.spa : '0;
        out_data_next.reply_valid      = reply;
        out_data_next.reply_dst_mac    = reply ? rec.sha : '0;
        out_data_next.reply_sender_mac = reply ? own_mac : '0;
        out_data_next.reply_sender_ip  = reply ? rec.tpa : '0;
        out_data_next.reply_target_ip  = reply ? rec.spa : '0;

        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_data_reg;

endmodule

/* rtl/arp_request_responder.sv */
// arp_request_responder: top level of the arp request responder
// depends on arp_rr_pkg, arp_rr_front, arp_rr_queue, arp_rr_back
`timescale 1ns / 1ps

// Takes one byte of a received ARP payload per transfer on rx and, on the byte
// marked frame_end, produces exactly one result transfer on res. While res is
// not stalled, bytes stream in at one per clock with no gaps needed, and frames
// may be as short as one byte, so a result per clock is sustained; the limit is
// the single rx byte lane. A frame's result passes through the queue and then
// the result register before res_valid rises. A two-entry queue separates the
// capture side from the result register, so rx keeps flowing while a result
// waits; rx_ready drops only when that queue is full. own_ip (index 0) and
// own_mac (index 1) are written through cfg_we/cfg_index/cfg_data and reset to
// zero; change them only while no frame is in flight.
module arp_request_responder
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rx_valid,
    output logic                                rx_ready,
    input  arp_rr_pkg::rx_item_t                rx_item,
    output logic                                res_valid,
    input  logic                                res_ready,
    output arp_rr_pkg::res_item_t               res_item,
    input  logic                                cfg_we,
    input  logic [arp_rr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [arp_rr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [31:0]         own_ip_reg;
    logic [31:0]         own_ip_next;
    logic [47:0]         own_mac_reg;
    logic [47:0]         own_mac_next;
    logic                rx_xfer;
    logic                push;
    logic                pop;
    arp_rr_pkg::rec_t    front_rec;
    arp_rr_pkg::rec_t    head_rec;
    arp_rr_pkg::q_stat_t q_stat;

    always_comb
    begin
        own_ip_next  = own_ip_reg;
        own_mac_next = own_mac_reg;
        if (cfg_we)
        begin
            case (arp_rr_pkg::cfg_reg_t'(cfg_index))
                arp_rr_pkg::REG_OWN_IP:  own_ip_next  = cfg_data[31:0];
                arp_rr_pkg::REG_OWN_MAC: own_mac_next = cfg_data[47:0];
                default:                 own_ip_next  = own_ip_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= '0;
            own_mac_reg <= '0;
        end
        else
        begin
            own_ip_reg  <= own_ip_next;
            own_mac_reg <= own_mac_next;
        end
    end

    assign rx_ready = !q_stat.full;
    assign rx_xfer  = rx_valid && rx_ready;

    arp_rr_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (rx_xfer),
        .item   (rx_item),
        .push   (push),
        .rec    (front_rec)
    );

    arp_rr_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_rec (front_rec),
        .pop    (pop),
        .rd_rec (head_rec),
        .stat   (q_stat)
    );

    arp_rr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec       (head_rec),
        .rec_valid (q_stat.not_empty),
        .pop       (pop),
        .own_ip    (own_ip_reg),
        .own_mac   (own_mac_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    // a last-byte transfer always lands in the queue
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        rx_xfer && rx_item.frame_end |=> q_stat.not_empty)
        else $error("frame end transfer did not reach the queue");

    a_reply_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.reply_valid |-> res_item.packet_ok)
        else $error("reply flagged on a malformed packet");

    a_learn_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.learn_valid |-> res_item.packet_ok)
        else $error("learn flagged on a malformed packet");

    a_bad_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.packet_ok |->
            res_item.learn_mac == '0 && res_item.learn_ip == '0
            && res_item.reply_sender_mac == '0)
        else $error("malformed packet carries nonzero fields");

endmodule

/* tb/arp_verdict_checker.sv */
// arp_verdict_checker: watches the rx, res and cfg ports of arp_request_responder,
// predicts the verdict of every frame and compares it with each res transfer
// depends on arp_rr_pkg
`timescale 1ns / 1ps

module arp_verdict_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rx_valid,
    input  logic                                rx_ready,
    input  arp_rr_pkg::rx_item_t                rx_item,
    input  logic                                res_valid,
    input  logic                                res_ready,
    input  arp_rr_pkg::res_item_t               res_item,
    input  logic                                cfg_we,
    input  logic [arp_rr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [arp_rr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                  error_count,
    output int                                  pending
);

    import arp_rr_pkg::*;

    logic [7:0]       hdr_bytes [0:27];
    logic [CNT_W-1:0] byte_cnt;
    logic [31:0]      own_ip_q;
    logic [47:0]      own_mac_q;
    res_item_t        frame_verdicts [$];
    res_item_t        want;
    int               errs;

    task automatic compare_field(input string label, input logic [47:0] exp_val,
                                 input logic [47:0] got_val);
        begin
            if (exp_val !== got_val)
            begin
                errs++;
                $display("%0t: %s expected %h got %h", $time, label, exp_val, got_val);
            end
        end
    endtask

    // verdict of the frame whose last byte was just taken
    function automatic res_item_t judge_frame();
        logic [15:0] htype;
        logic [15:0] ptype;
        logic [15:0] oper;
        logic [7:0]  hlen;
        logic [7:0]  plen;
        logic [47:0] sha;
        logic [31:0] spa;
        logic [31:0] tpa;
        logic        ok;
        res_item_t   v;
        begin
            htype = {hdr_bytes[0], hdr_bytes[1]};
            ptype = {hdr_bytes[2], hdr_bytes[3]};
            hlen  = hdr_bytes[4];
            plen  = hdr_bytes[5];
            oper  = {hdr_bytes[6], hdr_bytes[7]};
            sha   = {hdr_bytes[8], hdr_bytes[9], hdr_bytes[10], hdr_bytes[11],
                     hdr_bytes[12], hdr_bytes[13]};
            spa   = {hdr_bytes[14], hdr_bytes[15], hdr_bytes[16], hdr_bytes[17]};
            tpa   = {hdr_bytes[24], hdr_bytes[25], hdr_bytes[26], hdr_bytes[27]};
            ok = (byte_cnt == HEADER_LEN) && htype == HTYPE_ETH && ptype == PTYPE_IPV4
                 && hlen == HLEN_MAC && plen == PLEN_IPV4 && sha != '0 && sha != '1;
            v = '0;
            if (ok)
            begin
                v.packet_ok   = 1'b1;
                // group bit is the lsb of the first mac octet
                v.learn_valid = !sha[40] && spa != '0 && spa != '1 && spa[31:28] != 4'hE;
                v.learn_mac   = sha;
                v.learn_ip    = spa;
            end
            if (ok && oper == OPER_REQ && tpa == own_ip_q)
            begin
                v.reply_valid      = 1'b1;
                v.reply_dst_mac    = sha;
                v.reply_sender_mac = own_mac_q;
                v.reply_sender_ip  = tpa;
                v.reply_target_ip  = spa;
            end
            return v;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt = '0;
            own_ip_q = '0;
            own_mac_q = '0;
            frame_verdicts.delete();
            errs = 0;
            error_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (frame_verdicts.size() == 0)
                begin
                    errs++;
                    $display("%0t: result expected none got %h", $time, res_item);
                end
                else
                begin
                    want = frame_verdicts.pop_front();
                    compare_field("packet_ok", want.packet_ok, res_item.packet_ok);
                    compare_field("learn_valid", want.learn_valid, res_item.learn_valid);
                    compare_field("learn_mac", want.learn_mac, res_item.learn_mac);
                    compare_field("learn_ip", want.learn_ip, res_item.learn_ip);
                    compare_field("reply_valid", want.reply_valid, res_item.reply_valid);
                    compare_field("reply_dst_mac", want.reply_dst_mac, res_item.reply_dst_mac);
                    compare_field("reply_sender_mac", want.reply_sender_mac,
                                  res_item.reply_sender_mac);
                    compare_field("reply_sender_ip", want.reply_sender_ip,
                                  res_item.reply_sender_ip);
                    compare_field("reply_target_ip", want.reply_target_ip,
                                  res_item.reply_target_ip);
                end
            end
            if (rx_valid && rx_ready)
            begin
                // bytes past the header are dropped
                if (byte_cnt < HEADER_LEN)
                begin
                    hdr_bytes[byte_cnt] = rx_item.rx_byte;
                    byte_cnt = byte_cnt + 1'b1;
                end
                if (rx_item.frame_end)
                begin
                    frame_verdicts.push_back(judge_frame());
                    byte_cnt = '0;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OWN_IP:  own_ip_q = cfg_data[31:0];
                    REG_OWN_MAC: own_mac_q = cfg_data;
                    default: ;
                endcase
            end
            error_count <= errs;
            pending <= frame_verdicts.size();
        end
    end

endmodule

/* tb/tb_arp_request_responder.sv */
// tb_arp_request_responder: stimulus and verdict for arp_request_responder
// streams arp frames of many shapes under several own_ip/own_mac settings
// depends on arp_rr_pkg, arp_request_responder and arp_verdict_checker
`timescale 1ns / 1ps

module tb_arp_request_responder;

    import arp_rr_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;

    typedef enum int {
        FRAME_REQ_OURS,
        FRAME_REQ_OTHER,
        FRAME_REPLY,
        FRAME_BAD_FIELD,
        FRAME_SHA_EDGE,
        FRAME_SPA_EDGE,
        FRAME_SHORT,
        FRAME_NOISE
    } frame_kind_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  rx_valid;
    logic                  rx_ready;
    rx_item_t              rx_item;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    res_item_t             res_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int          error_count;
    int          pending;
    bit          sender_idles;
    bit          sink_stalls = 1'b0;
    int          ready_hold = 0;
    int unsigned cycle_count = 0;
    logic [31:0] cur_ip;
    logic [7:0]  frame_bytes [$];
    int          phase_bytes;
    int          phase_frames;

    always #5 clk = ~clk;

    arp_request_responder uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_item   (rx_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    arp_verdict_checker checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_ready    (rx_ready),
        .rx_item     (rx_item),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_item    (res_item),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .pending     (pending)
    );

    // result sink: when sink_stalls is set, ready bursts alternate with stalls, mostly short
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            ready_hold <= 0;
        end
        else if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if (res_ready && sink_stalls && $urandom_range(0, 1) == 1)
        begin
            res_ready <= 1'b0;
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
        end
        else
        begin
            res_ready <= 1'b1;
            ready_hold <= $urandom_range(0, 5);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_arp_request_responder: errors");
            $finish;
        end
    end

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        begin
            w = {$urandom, $urandom};
            return w[47:0];
        end
    endfunction

    function automatic int idle_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (!sender_idles || r < 60)
                return 0;
            if (r < 92)
                return $urandom_range(1, 3);
            return $urandom_range(8, 30);
        end
    endfunction

    function automatic frame_kind_t pick_kind();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 30) return FRAME_REQ_OURS;
            if (r < 42) return FRAME_REQ_OTHER;
            if (r < 50) return FRAME_REPLY;
            if (r < 62) return FRAME_BAD_FIELD;
            if (r < 72) return FRAME_SHA_EDGE;
            if (r < 82) return FRAME_SPA_EDGE;
            if (r < 92) return FRAME_SHORT;
            return FRAME_NOISE;
        end
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            @(posedge clk);
            cfg_we <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        rx_item_t it;
        int       gap;
        begin
            it.rx_byte = b;
            it.frame_end = last;
            rx_item <= it;
            rx_valid <= 1'b1;
            do @(posedge clk); while (!rx_ready);
            phase_bytes++;
            gap = idle_gap();
            if (gap != 0)
            begin
                rx_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_frame();
        int i;
        begin
            for (i = 0; i < frame_bytes.size(); i++)
                push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
            phase_frames++;
        end
    endtask

    // sender holds off until every verdict is in and the pipeline has settled
    task automatic wait_idle();
        begin
            rx_valid <= 1'b0;
            do @(posedge clk); while (pending != 0);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic build_frame(input frame_kind_t kind);
        logic [15:0]  htype;
        logic [15:0]  ptype;
        logic [15:0]  oper;
        logic [7:0]   hlen;
        logic [7:0]   plen;
        logic [47:0]  sha;
        logic [47:0]  tha;
        logic [31:0]  spa;
        logic [31:0]  tpa;
        logic [223:0] hdr;
        int           len;
        int           pick;
        int           i;
        begin
            htype = HTYPE_ETH;
            ptype = PTYPE_IPV4;
            hlen = HLEN_MAC;
            plen = PLEN_IPV4;
            oper = OPER_REQ;
            sha = rand48();
            sha[40] = 1'b0;
            sha[0] = 1'b1;
            spa = $urandom;
            tha = rand48();
            tpa = cur_ip;
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(HEADER_LEN + 1, 44) : HEADER_LEN;
            pick = $urandom_range(0, 4);
            case (kind)
                FRAME_REQ_OTHER: tpa = $urandom;
                FRAME_REPLY:
                begin
                    oper = OPER_REPLY;
                    if (pick[0])
                        tpa = $urandom;
                end
                FRAME_BAD_FIELD:
                begin
                    case (pick)
                        0: htype ^= 16'h1 << $urandom_range(0, 15);
                        1: ptype ^= 16'h1 << $urandom_range(0, 15);
                        2: hlen ^= 8'h1 << $urandom_range(0, 7);
                        3: plen ^= 8'h1 << $urandom_range(0, 7);
                        default: oper = 16'($urandom);
                    endcase
                end
                FRAME_SHA_EDGE:
                begin
                    case (pick)
                        0: sha = '0;
                        1: sha = '1;
                        2: sha[40] = 1'b1;
                        default: sha = rand48();
                    endcase
                    if ($urandom_range(0, 1) == 1)
                        tpa = $urandom;
                end
                FRAME_SPA_EDGE:
                begin
                    case (pick)
                        0: spa = '0;
                        1: spa = '1;
                        2: spa[31:28] = 4'hE;
                        3: spa[31:28] = 4'hF;
                        default: spa[31:28] = 4'hD;
                    endcase
                end
                FRAME_SHORT: len = $urandom_range(1, HEADER_LEN - 1);
                default: ;
            endcase
            frame_bytes = {};
            if (kind == FRAME_NOISE)
            begin
                len = $urandom_range(1, 40);
                repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                hdr = {htype, ptype, hlen, plen, oper, sha, spa, tha, tpa};
                for (i = 0; i < HEADER_LEN; i++)
                    frame_bytes.push_back(hdr[223 - 8 * i -: 8]);
                while (frame_bytes.size() < len)
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
                while (frame_bytes.size() > len)
                    void'(frame_bytes.pop_back());
            end
        end
    endtask

    initial
    begin : stimulus
        int          phase;
        logic [47:0] mac_val;
        logic [47:0] ip_word;

        rst_n = 1'b0;
        rx_valid = 1'b0;
        rx_item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sender_idles = 1'b1;
        cur_ip = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    cur_ip = '0;
                    mac_val = '0;
                end
                1:
                begin
                    cur_ip = '1;
                    mac_val = '1;
                end
                default:
                begin
                    cur_ip = $urandom;
                    mac_val = rand48();
                end
            endcase
            // junk above bit 31 must not reach own_ip
            ip_word = rand48();
            ip_word[31:0] = cur_ip;
            write_reg(REG_OWN_IP, ip_word);
            write_reg(REG_OWN_MAC, mac_val);
            sender_idles = (phase == 0 || phase == 1);
            sink_stalls <= (phase == 0 || phase == 3);
            phase_bytes = 0;
            phase_frames = 0;

            if (phase == 0)
            begin
                // one-byte frames at both byte extremes, a two-byte frame, then a truncated header
                frame_bytes = {};
                frame_bytes.push_back(8'h00);
                send_frame();
                frame_bytes = {};
                frame_bytes.push_back(8'hFF);
                send_frame();
                frame_bytes = {};
                frame_bytes.push_back(8'h55);
                frame_bytes.push_back(8'hAA);
                send_frame();
                build_frame(FRAME_SHORT);
                send_frame();
            end

            while (phase_bytes < 190 || phase_frames < 6)
            begin
                build_frame(pick_kind());
                send_frame();
            end
        end

        wait_idle();
        if (error_count == 0)
            $display("tb_arp_request_responder: clean");
        else
            $display("tb_arp_request_responder: errors");
        $finish;
    end

endmodule
